@@ hw/rtl/hsswr_pkg.sv @@
package hsswr_pkg;

   // Widths fixed by the line protocol and the item fields.
   localparam int CFG_WIDTH    = 10;
   localparam int REG_COUNT    = 6;
   localparam int REG_IDX_BITS = 3;
   localparam int FRAME_BITS   = 40;
   localparam int TIMER_BITS_DEFAULT = 10;

   // Configuration register indexes.
   localparam logic [REG_IDX_BITS-1:0] REG_RESP_DELAY = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_RESP_LOW   = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_RESP_HIGH  = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_BIT_LOW    = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_ONE_HIGH   = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_ZERO_HIGH  = 3'd5;

   typedef logic [CFG_WIDTH-1:0] cfg_word_type;

   // Reset values of the configuration registers, in index order.
   localparam cfg_word_type CFG_RESET [REG_COUNT] = '{
      10'd30, 10'd80, 10'd80, 10'd50, 10'd70, 10'd27
   };

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_INIT = 2'd1,
      MODE_TX   = 2'd2,
      MODE_END  = 2'd3
   } mode_type;

   typedef struct packed {
      logic               host_level;
      logic        [15:0] humidity_tenths;
      logic signed [15:0] temperature_tenths;
   } req_type;

   typedef struct packed {
      logic     line_level;
      mode_type mode;
      logic     frame_done;
   } rsp_type;

endpackage

@@ hw/rtl/hsswr_frame.sv @@
module hsswr_frame
   import hsswr_pkg::*;
(
   input  logic signed [15:0]      temperature_tenths,
   input  logic        [15:0]      humidity_tenths,
   output logic [FRAME_BITS-1:0]   frame
);

   logic [15:0] neg_mag;
   logic [15:0] temp_sm;
   logic [9:0]  byte_sum;

   // Negative temperatures go out as sign and magnitude, the magnitude held to 15 bits.
   assign neg_mag = 16'(-temperature_tenths);

   always_comb begin
      if (temperature_tenths[15]) begin
         if (neg_mag[15]) begin
            temp_sm = 16'hffff;
         end else begin
            temp_sm = {1'b1, neg_mag[14:0]};
         end
      end else begin
         temp_sm = temperature_tenths;
      end
   end

   // Checksum is the low byte of the sum of the four data bytes.
   assign byte_sum = 10'(humidity_tenths[15:8]) + 10'(humidity_tenths[7:0])
                   + 10'(temp_sm[15:8]) + 10'(temp_sm[7:0]);

   assign frame = {humidity_tenths, temp_sm, byte_sum[7:0]};

endmodule

@@ hw/rtl/humidity_sensor_single_wire_responder_unit.sv @@
// Sensor side of a single-wire humidity and temperature link. Each item on the
// req_ channel is one 1 us tick carrying the host's line level and the current
// readings; every item gives exactly one rsp_ item with the level the sensor
// drives, the link mode and a pulse that marks the end of the 40-bit frame. The
// block takes one item per clock cycle unless req_stall is set; the whole state
// update for a tick is done between the item's acceptance and the result
// register, and a second result register lets a tick be taken while an earlier
// result still waits. The csr_ timing registers may be written at any time and
// act from the next tick. There is no clearing pass after reset.
module humidity_sensor_single_wire_responder_unit
   import hsswr_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_write,
   input  logic [REG_IDX_BITS-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]    csr_data
);

   localparam int CW = ((TIMER_BITS > CFG_WIDTH) ? TIMER_BITS : CFG_WIDTH) + 1;
   localparam logic [CW-1:0] FULL = {{(CW-1){1'b0}}, 1'b1} << TIMER_BITS;
   localparam logic [CW-1:0] ONE  = {{(CW-1){1'b0}}, 1'b1};
   localparam logic [5:0]    BIT_LAST = 6'(FRAME_BITS - 1);

   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_RLOW  = 3'd1,
      PH_RHIGH = 3'd2,
      PH_BLOW  = 3'd3,
      PH_BHIGH = 3'd4
   } phase_type;

   cfg_word_type cfg_ff [REG_COUNT];

   mode_type               mode_ff, mode_in;
   phase_type              phase_ff, phase_in;
   logic [TIMER_BITS-1:0]  tick_ff, tick_in;
   logic [5:0]             bit_ff, bit_in;
   logic [FRAME_BITS-1:0]  frame_ff, frame_in;
   logic                   prev_ff, prev_in;
   logic                   drive_ff, drive_in;
   logic                   done_in;

   rsp_type                out_data_ff, out_data_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                skid_data_ff, skid_data_in;
   logic                   skid_valid_ff, skid_valid_in;

   logic                   accept;
   logic                   take;
   logic                   falling;
   logic                   rising;
   logic [FRAME_BITS-1:0]  new_frame;
   cfg_word_type           len_sel;
   logic [CW-1:0]          len_eff;
   logic [CW-1:0]          tick_next;
   logic                   timer_done;

   assign accept    = req_valid && !req_stall;
   assign take      = rsp_valid && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Configuration registers; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            cfg_ff[i] <= CFG_RESET[i];
         end
      end else if (csr_write && (csr_index < REG_IDX_BITS'(REG_COUNT))) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   hsswr_frame u_frame (
      .temperature_tenths (req_data.temperature_tenths),
      .humidity_tenths    (req_data.humidity_tenths),
      .frame              (new_frame)
   );

   assign falling = prev_ff && !req_data.host_level;
   assign rising  = !prev_ff && req_data.host_level;

   // Length of the current transmit phase.
   always_comb begin
      case (phase_ff)
         PH_RLOW:  len_sel = cfg_ff[REG_RESP_LOW];
         PH_RHIGH: len_sel = cfg_ff[REG_RESP_HIGH];
         PH_BLOW:  len_sel = cfg_ff[REG_BIT_LOW];
         PH_BHIGH: len_sel = frame_ff[FRAME_BITS-1] ? cfg_ff[REG_ONE_HIGH]
                                                    : cfg_ff[REG_ZERO_HIGH];
         default:  len_sel = cfg_ff[REG_RESP_DELAY];
      endcase
   end

   // A zero length acts as one tick, and a length above the timer range is clipped to it.
   always_comb begin
      len_eff = CW'(len_sel);
      if (len_sel == '0) begin
         len_eff = ONE;
      end else if (len_eff > FULL) begin
         len_eff = FULL;
      end
   end

   assign tick_next  = CW'(tick_ff) + ONE;
   assign timer_done = (tick_next >= len_eff);

   // Next link state for the tick being accepted.
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      frame_in = frame_ff;
      drive_in = drive_ff;
      done_in  = 1'b0;
      prev_in  = req_data.host_level;
      case (mode_ff)
         MODE_IDLE: begin
            if (falling) begin
               mode_in = MODE_INIT;
            end
         end
         MODE_INIT: begin
            if (rising) begin
               mode_in  = MODE_TX;
               phase_in = PH_WAIT;
               tick_in  = '0;
               bit_in   = '0;
               frame_in = new_frame;
            end
         end
         MODE_TX: begin
            tick_in = timer_done ? '0 : tick_next[TIMER_BITS-1:0];
            if (timer_done) begin
               case (phase_ff)
                  PH_RLOW: begin
                     drive_in = 1'b1;
                     phase_in = PH_RHIGH;
                  end
                  PH_RHIGH: begin
                     drive_in = 1'b0;
                     phase_in = PH_BLOW;
                  end
                  PH_BLOW: begin
                     drive_in = 1'b1;
                     phase_in = PH_BHIGH;
                  end
                  PH_BHIGH: begin
                     drive_in = 1'b0;
                     frame_in = {frame_ff[FRAME_BITS-2:0], 1'b0};
                     if (bit_ff >= BIT_LAST) begin
                        bit_in   = '0;
                        phase_in = PH_WAIT;
                        mode_in  = MODE_END;
                        done_in  = 1'b1;
                     end else begin
                        bit_in   = bit_ff + 6'd1;
                        phase_in = PH_BLOW;
                     end
                  end
                  default: begin
                     drive_in = 1'b0;
                     phase_in = PH_RLOW;
                  end
               endcase
            end
         end
         default: begin
            if (rising) begin
               mode_in = MODE_IDLE;
            end
         end
      endcase
   end

   // Result register with a skid stage behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = '{line_level: drive_in, mode: mode_in, frame_done: done_in};
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = '{line_level: drive_in, mode: mode_in, frame_done: done_in};
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   // Link state advances only on accepted items; the result registers follow every cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         phase_ff      <= PH_WAIT;
         tick_ff       <= '0;
         bit_ff        <= '0;
         frame_ff      <= '0;
         prev_ff       <= 1'b1;
         drive_ff      <= 1'b1;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            bit_ff   <= bit_in;
            frame_ff <= frame_in;
            prev_ff  <= prev_in;
            drive_ff <= drive_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

@@ hw/rtl/hsswr_checker.sv @@
module hsswr_checker
   import hsswr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A result held back by the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or vanished");

   // The end-of-frame pulse only comes with the line pulled low in end mode.
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.mode == MODE_END && !rsp_data.line_level)
      else $error("frame end flagged outside end mode");

   // No result survives a reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending straight after reset");

   // The input is only held off while a result is waiting on the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // After an accepted tick, a result is always valid on the next cycle.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

endmodule

bind humidity_sensor_single_wire_responder_unit hsswr_checker u_hsswr_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import hsswr_pkg::*;

   // Transmit phase codes of the line emulation.
   localparam logic [2:0] PHASE_WAIT      = 3'd0;
   localparam logic [2:0] PHASE_RESP_LOW  = 3'd1;
   localparam logic [2:0] PHASE_RESP_HIGH = 3'd2;
   localparam logic [2:0] PHASE_BIT_LOW   = 3'd3;
   localparam logic [2:0] PHASE_BIT_HIGH  = 3'd4;

   localparam int unsigned TIMER_SPAN   = 1 << TIMER_BITS_DEFAULT;
   localparam int unsigned LAST_BIT     = FRAME_BITS - 1;
   localparam int unsigned RANDOM_TICKS = 100;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [REG_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]    csr_data = '0;

   // Shared control between the stimulus, the receiver and the result check.
   bit          calm = 1'b0;
   bit          hold_wanted = 1'b0;
   bit          offering = 1'b0;
   int unsigned error_count = 0;
   int unsigned tick_total = 0;
   int unsigned frame_total = 0;
   int unsigned setting_total = 0;
   int unsigned cycle_count = 0;

   // Line states still owed by the block, oldest first.
   rsp_type pending_line_states [$];

   // Own copy of the sensor state and timing registers.
   mode_type     model_mode;
   logic [2:0]   model_phase;
   int unsigned  model_ticks;
   int unsigned  model_bit;
   logic [39:0]  model_frame;
   logic         model_prev_host;
   logic         model_line;
   cfg_word_type model_regs [REG_COUNT];

   humidity_sensor_single_wire_responder_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Builds the 40-bit frame: humidity, sign-magnitude temperature, byte checksum.
   function automatic logic [39:0] assemble_frame(input logic [15:0] hum,
                                                  input logic [15:0] temp_raw);
      logic [16:0] magnitude;
      logic [15:0] temp_word;
      logic [7:0]  checksum;
      if (temp_raw[15]) begin
         magnitude = 17'h10000 - {1'b0, temp_raw};
         // The most negative reading cannot be shown, so it is clipped.
         if (magnitude > 17'h07fff) begin
            magnitude = 17'h07fff;
         end
         temp_word = {1'b1, magnitude[14:0]};
      end else begin
         temp_word = temp_raw;
      end
      checksum = hum[15:8] + hum[7:0] + temp_word[15:8] + temp_word[7:0];
      return {hum, temp_word, checksum};
   endfunction

   // Counts one tick of the current phase; true on the tick the phase ends.
   function automatic bit phase_over(input cfg_word_type len_reg);
      int unsigned len;
      int unsigned next_count;
      len = len_reg;
      if (len == 0) begin
         len = 1;
      end
      if (len > TIMER_SPAN) begin
         len = TIMER_SPAN;
      end
      next_count = model_ticks + 1;
      if (next_count >= len) begin
         model_ticks = 0;
         return 1'b1;
      end
      model_ticks = next_count % TIMER_SPAN;
      return 1'b0;
   endfunction

   // One tick of the transmit sequence; true when the last bit ends.
   function automatic bit advance_transmit();
      logic bit_now;
      case (model_phase)
         PHASE_RESP_LOW: begin
            if (phase_over(model_regs[REG_RESP_LOW])) begin
               model_line  = 1'b1;
               model_phase = PHASE_RESP_HIGH;
            end
         end
         PHASE_RESP_HIGH: begin
            if (phase_over(model_regs[REG_RESP_HIGH])) begin
               model_line  = 1'b0;
               model_phase = PHASE_BIT_LOW;
            end
         end
         PHASE_BIT_LOW: begin
            if (phase_over(model_regs[REG_BIT_LOW])) begin
               model_line  = 1'b1;
               model_phase = PHASE_BIT_HIGH;
            end
         end
         PHASE_BIT_HIGH: begin
            bit_now = model_frame[39];
            if (phase_over(bit_now ? model_regs[REG_ONE_HIGH] : model_regs[REG_ZERO_HIGH])) begin
               model_line  = 1'b0;
               model_frame = model_frame << 1;
               if (model_bit >= LAST_BIT) begin
                  model_bit   = 0;
                  model_phase = PHASE_WAIT;
                  model_mode  = MODE_END;
                  return 1'b1;
               end
               model_bit   = model_bit + 1;
               model_phase = PHASE_BIT_LOW;
            end
         end
         default: begin
            // Unused phase codes behave as the wait before the response.
            if (phase_over(model_regs[REG_RESP_DELAY])) begin
               model_line  = 1'b0;
               model_phase = PHASE_RESP_LOW;
            end
         end
      endcase
      return 1'b0;
   endfunction

   // Applies one tick to the sensor copy and gives the line state after it.
   function automatic rsp_type emulate_tick(input req_type item);
      rsp_type line_state;
      logic    rise;
      logic    fall;
      logic    done;
      fall = model_prev_host && !item.host_level;
      rise = !model_prev_host && item.host_level;
      done = 1'b0;
      model_prev_host = item.host_level;
      case (model_mode)
         MODE_IDLE: begin
            if (fall) begin
               model_mode = MODE_INIT;
            end
         end
         MODE_INIT: begin
            if (rise) begin
               model_mode  = MODE_TX;
               model_phase = PHASE_WAIT;
               model_ticks = 0;
               model_bit   = 0;
               model_frame = assemble_frame(item.humidity_tenths, item.temperature_tenths);
            end
         end
         MODE_TX: begin
            done = advance_transmit();
         end
         default: begin
            if (rise) begin
               model_mode = MODE_IDLE;
            end
         end
      endcase
      if (done) begin
         frame_total++;
      end
      line_state.line_level = model_line;
      line_state.mode       = model_mode;
      line_state.frame_done = done;
      return line_state;
   endfunction

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   // Mostly very short timings so that frames stay brief.
   function automatic int unsigned short_len();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(5, 24);
      end
      return $urandom_range(1, 4);
   endfunction

   // Offers one tick and waits until the block takes it.
   task automatic send_tick(input logic host, input logic [15:0] hum, input logic [15:0] temp);
      req_type item;
      item.host_level         = host;
      item.humidity_tenths    = hum;
      item.temperature_tenths = temp;
      req_valid <= 1'b1;
      req_data  <= item;
      offering = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_line_states.push_back(emulate_tick(item));
      tick_total++;
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic stop_offering();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // Writes one timing register once the block has nothing outstanding.
   task automatic write_register(input logic [REG_IDX_BITS-1:0] idx,
                                 input cfg_word_type value);
      stop_offering();
      while (pending_line_states.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      model_regs[idx] = value;
      csr_write <= 1'b0;
   endtask

   // Writes all six timing registers once the block has nothing outstanding.
   task automatic set_timing(input int unsigned delay_t, input int unsigned resp_low_t,
                             input int unsigned resp_high_t, input int unsigned bit_low_t,
                             input int unsigned one_t, input int unsigned zero_t);
      cfg_word_type vals [REG_COUNT];
      int           idx;
      stop_offering();
      while (pending_line_states.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      vals[REG_RESP_DELAY] = CFG_WIDTH'(delay_t);
      vals[REG_RESP_LOW]   = CFG_WIDTH'(resp_low_t);
      vals[REG_RESP_HIGH]  = CFG_WIDTH'(resp_high_t);
      vals[REG_BIT_LOW]    = CFG_WIDTH'(bit_low_t);
      vals[REG_ONE_HIGH]   = CFG_WIDTH'(one_t);
      vals[REG_ZERO_HIGH]  = CFG_WIDTH'(zero_t);
      for (idx = 0; idx < REG_COUNT; idx++) begin
         csr_write <= 1'b1;
         csr_index <= REG_IDX_BITS'(idx);
         csr_data  <= vals[idx];
         @(posedge clock);
         model_regs[idx] = vals[idx];
      end
      csr_write <= 1'b0;
      setting_total++;
   endtask

   // Toggles the host line until the link is idle again; edges in transmit are ignored.
   task automatic return_to_idle();
      while (model_mode != MODE_IDLE) begin
         if (model_mode == MODE_TX) begin
            send_tick(1'($urandom_range(0, 1)), rand16(), rand16());
         end else begin
            send_tick(!model_prev_host, rand16(), rand16());
         end
      end
   endtask

   // A well-formed exchange: host start pulse, release, whole frame, then release.
   task automatic run_frame(input logic [15:0] hum, input logic [15:0] temp,
                            input int unsigned lead);
      repeat (lead) send_tick(1'b1, rand16(), rand16());
      repeat ($urandom_range(1, 4)) send_tick(1'b0, rand16(), rand16());
      send_tick(1'b1, hum, temp);
      while (model_mode == MODE_TX) begin
         send_tick(1'($urandom_range(0, 1)), rand16(), rand16());
      end
      // A falling edge here is dropped, as the link has already ended.
      repeat ($urandom_range(1, 3)) send_tick(1'b0, rand16(), rand16());
      return_to_idle();
   endtask

   // Random host levels with random readings, in whatever mode they land.
   task automatic line_noise(input int unsigned count);
      repeat (count) send_tick(1'($urandom_range(0, 1)), rand16(), rand16());
      return_to_idle();
   endtask

   // Reset values of the wait, the response and the zero-bit high time, with no idling;
   // the bit lead-in and the one-bit high are shortened so that the frame stays brief.
   task automatic test_reset_timing();
      write_register(REG_BIT_LOW, 10'd1);
      write_register(REG_ONE_HIGH, 10'd1);
      calm = 1'b1;
      run_frame(16'hffff, 16'h7fff, 3);
      calm = 1'b0;
   endtask

   // Extreme readings, saturation, and the shortest and zero-length timings.
   task automatic test_line_cases();
      set_timing(3, 2, 2, 1, 2, 1);
      run_frame(16'h0000, 16'h0000, 2);
      run_frame(16'hffff, 16'h7fff, 1);
      run_frame(16'h1234, 16'hffff, 4);
      run_frame(16'h00ff, 16'h8000, 2);
      run_frame(16'hff00, 16'h8001, 1);
      set_timing(0, 0, 0, 0, 0, 0);
      run_frame(16'h5a5a, 16'h00fa, 2);
   endtask

   // Full-scale response wait; the rest of the frame runs at the shortest timings.
   task automatic test_timing_extremes();
      set_timing(1023, 1, 1, 1, 1, 1);
      run_frame(16'h0001, 16'h0000, 2);
   endtask

   // Random short timings and readings, with some noise and broken starts.
   task automatic test_random_frames();
      int unsigned start_ticks;
      start_ticks = tick_total;
      while (tick_total - start_ticks < RANDOM_TICKS) begin
         set_timing(short_len(), short_len(), short_len(), short_len(), short_len(),
                    short_len());
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 3) == 0) begin
               line_noise($urandom_range(1, 40));
            end
            run_frame(rand16(), rand16(), $urandom_range(1, 6));
         end
      end
   endtask

   // The receiver holds off for a long stretch while ticks keep coming.
   task automatic test_input_backpressure();
      set_timing(1, 1, 1, 1, 2, 1);
      calm = 1'b1;
      hold_wanted = 1'b1;
      run_frame(rand16(), rand16(), 20);
      calm = 1'b0;
   endtask

   // Receiver: random stalls, plus one long hold when asked.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
      end
   end

   // Each result item is compared with the oldest outstanding line state.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_line_states.size() == 0) begin
            $error("result item with nothing outstanding: line_level %0d mode %0d frame_done %0d",
                   rsp_data.line_level, rsp_data.mode, rsp_data.frame_done);
            error_count++;
         end else begin
            want = pending_line_states.pop_front();
            if (rsp_data.line_level !== want.line_level) begin
               $error("line_level: expected %0d, got %0d", want.line_level, rsp_data.line_level);
               error_count++;
            end
            if (rsp_data.mode !== want.mode) begin
               $error("mode: expected %0d, got %0d", want.mode, rsp_data.mode);
               error_count++;
            end
            if (rsp_data.frame_done !== want.frame_done) begin
               $error("frame_done: expected %0d, got %0d", want.frame_done, rsp_data.frame_done);
               error_count++;
            end
         end
      end
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int idx;
      model_mode      = MODE_IDLE;
      model_phase     = PHASE_WAIT;
      model_ticks     = 0;
      model_bit       = 0;
      model_frame     = '0;
      model_prev_host = 1'b1;
      model_line      = 1'b1;
      for (idx = 0; idx < REG_COUNT; idx++) begin
         model_regs[idx] = CFG_RESET[idx];
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_timing();
      test_line_cases();
      test_timing_extremes();
      test_random_frames();
      test_input_backpressure();

      // Let every outstanding result arrive, then watch for strays.
      stop_offering();
      while (pending_line_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d ticks covering %0d complete frames under %0d timing settings,",
               tick_total, frame_total, setting_total);
      $display("with saturated and extreme readings, zero and full-scale timings and a long hold.");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/hsswr_pkg.sv
hw/rtl/hsswr_frame.sv
hw/rtl/humidity_sensor_single_wire_responder_unit.sv
hw/rtl/hsswr_checker.sv
tb/testbench.sv
